@@ rtl/stk_pkg.sv @@
package stk_pkg;

   localparam int VALUE_W = 32;
   localparam int SUM_W   = 40;
   localparam int REQ_W   = 2;
   localparam int FAULT_W = 2;
   localparam int STEP_W  = $clog2(SUM_W + 1);
   localparam int ENTRY_W = 3 * VALUE_W;

   localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
   localparam logic [REQ_W-1:0] REQ_POP  = 2'd1;

   localparam logic [FAULT_W-1:0] FAULT_OK        = 2'd0;
   localparam logic [FAULT_W-1:0] FAULT_UNDERFLOW = 2'd1;
   localparam logic [FAULT_W-1:0] FAULT_OVERFLOW  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_REPLY
   } ctl_state_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic signed [VALUE_W-1:0] run_min;
      logic signed [VALUE_W-1:0] run_max;
   } entry_type;

endpackage

@@ rtl/stk_ram.sv @@
module stk_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ rtl/stk_div.sv @@
module stk_div #(
   parameter int CW = 9
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [stk_pkg::SUM_W-1:0]     dividend,
   input  logic [CW-1:0]                        divisor,
   output logic                                 done,
   output logic signed [stk_pkg::VALUE_W-1:0]   quotient
);

   import stk_pkg::*;

   // Restoring radix-2 division of the magnitude, one quotient bit a cycle.
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                neg_ff, neg_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   logic [CW-1:0]       rem_ff, rem_in;
   logic [SUM_W-1:0]    quo_ff, quo_in;
   logic [CW:0]         rem_shift;
   logic [CW:0]         rem_diff;
   logic                fits;
   logic [SUM_W-1:0]    quo_signed;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[SUM_W-1]};
      rem_diff  = rem_shift - {1'b0, divisor};
      fits      = (rem_shift >= {1'b0, divisor});
      busy_in   = busy_ff;
      done_in   = 1'b0;
      neg_in    = neg_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      if (start) begin
         neg_in  = dividend[SUM_W-1];
         quo_in  = dividend[SUM_W-1] ? -dividend : dividend;
         rem_in  = '0;
         cnt_in  = STEP_W'(SUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? rem_diff[CW-1:0] : rem_shift[CW-1:0];
         quo_in = {quo_ff[SUM_W-2:0], fits};
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quo_signed = neg_ff ? -quo_ff : quo_ff;
   assign quotient   = quo_signed[VALUE_W-1:0];
   assign done       = done_ff;

endmodule

@@ rtl/stack_with_running_stats_unit.sv @@
// Bounded LIFO stack of signed 32-bit words with running statistics.
//
// Requests: a word is taken at a rising edge where start is high and busy
// is low. req_type selects push (0), pop (1) or peek (2; the unused code 3
// also peeks). req_push_value is only looked at by a push.
// Results: exactly one result word per request, shown for one cycle while
// rsp_valid is high. The receiver cannot stall, so it must take the word
// in that cycle. The result gives the popped word, top, base, count, sum,
// least, greatest and the mean (sum / count, truncated towards zero).
// Flow: an accepted request runs through the states DIV_GO, DIV_WAIT and
// REPLY; a pop that leaves words behind first passes LOAD, which needs one
// memory read of the new top. DIV_WAIT waits on the 40-step serial divider
// for the mean. A result for an empty stack goes straight to REPLY. busy
// stays high until the result is shown, so no new request is taken before
// the result of the last one is out.
// Reset: synchronous, active high. It empties the stack and zeroes the sum;
// the word memory is not cleared, as only written entries are ever read.
module stack_with_running_stats_unit #(
   parameter int DEPTH = 256,
   localparam int CW = $clog2(DEPTH + 1),
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [stk_pkg::REQ_W-1:0]            req_type,
   input  logic signed [stk_pkg::VALUE_W-1:0]   req_push_value,
   output logic                                 rsp_valid,
   output logic signed [stk_pkg::VALUE_W-1:0]   rsp_popped_value,
   output logic signed [stk_pkg::VALUE_W-1:0]   rsp_top_value,
   output logic signed [stk_pkg::VALUE_W-1:0]   rsp_base_value,
   output logic [CW-1:0]                        rsp_entry_count,
   output logic signed [stk_pkg::SUM_W-1:0]     rsp_total_sum,
   output logic signed [stk_pkg::VALUE_W-1:0]   rsp_least_value,
   output logic signed [stk_pkg::VALUE_W-1:0]   rsp_greatest_value,
   output logic signed [stk_pkg::VALUE_W-1:0]   rsp_mean_value,
   output logic                                 rsp_is_empty,
   output logic [stk_pkg::FAULT_W-1:0]          rsp_fault
);

   import stk_pkg::*;

   // Control state.
   ctl_state_type state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // The top entry is held in registers, so a push never has to read the
   // memory; only a pop must fetch the entry beneath the old top.
   logic signed [VALUE_W-1:0] top_ff, top_in;
   logic signed [VALUE_W-1:0] min_ff, min_in;
   logic signed [VALUE_W-1:0] max_ff, max_in;
   logic signed [VALUE_W-1:0] base_ff, base_in;
   logic signed [VALUE_W-1:0] popped_ff, popped_in;
   logic [FAULT_W-1:0]        fault_ff, fault_in;
   logic signed [VALUE_W-1:0] mean_ff, mean_in;

   // Result registers.
   logic signed [VALUE_W-1:0] r_popped_ff, r_popped_in;
   logic signed [VALUE_W-1:0] r_top_ff, r_top_in;
   logic signed [VALUE_W-1:0] r_base_ff, r_base_in;
   logic [CW-1:0]             r_count_ff, r_count_in;
   logic signed [SUM_W-1:0]   r_sum_ff, r_sum_in;
   logic signed [VALUE_W-1:0] r_min_ff, r_min_in;
   logic signed [VALUE_W-1:0] r_max_ff, r_max_in;
   logic signed [VALUE_W-1:0] r_mean_ff, r_mean_in;
   logic                      r_empty_ff, r_empty_in;
   logic [FAULT_W-1:0]        r_fault_ff, r_fault_in;

   // Memory and divider connections.
   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   entry_type                 wr_entry;
   logic                      rd_en;
   logic [AW-1:0]             rd_addr;
   entry_type                 rd_entry;
   logic [CW-1:0]             below_top;
   logic                      div_start;
   logic                      div_done;
   logic signed [VALUE_W-1:0] div_quotient;
   logic                      accept;
   logic                      empty_now;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign below_top = count_ff - CW'(2);
   assign empty_now = (count_ff == '0);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      top_in       = top_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      base_in      = base_ff;
      popped_in    = popped_ff;
      fault_in     = fault_ff;
      mean_in      = mean_ff;
      rsp_valid_in = 1'b0;
      r_popped_in  = r_popped_ff;
      r_top_in     = r_top_ff;
      r_base_in    = r_base_ff;
      r_count_in   = r_count_ff;
      r_sum_in     = r_sum_ff;
      r_min_in     = r_min_ff;
      r_max_in     = r_max_ff;
      r_mean_in    = r_mean_ff;
      r_empty_in   = r_empty_ff;
      r_fault_in   = r_fault_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[AW-1:0];
      wr_entry.value   = req_push_value;
      wr_entry.run_min = (!empty_now && (min_ff < req_push_value)) ? min_ff : req_push_value;
      wr_entry.run_max = (!empty_now && (max_ff > req_push_value)) ? max_ff : req_push_value;
      rd_en        = 1'b0;
      rd_addr      = below_top[AW-1:0];
      div_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               popped_in = '0;
               fault_in  = FAULT_OK;
               state_in  = ST_DIV_GO;
               if (req_type == REQ_PUSH) begin
                  if (count_ff == CW'(DEPTH)) begin
                     fault_in = FAULT_OVERFLOW;
                  end else begin
                     wr_en    = 1'b1;
                     top_in   = req_push_value;
                     min_in   = wr_entry.run_min;
                     max_in   = wr_entry.run_max;
                     count_in = count_ff + CW'(1);
                     sum_in   = sum_ff + SUM_W'(req_push_value);
                     if (empty_now) begin
                        base_in = req_push_value;
                     end
                  end
               end else if (empty_now) begin
                  fault_in = FAULT_UNDERFLOW;
                  state_in = ST_REPLY;
               end else if (req_type == REQ_POP) begin
                  popped_in = top_ff;
                  count_in  = count_ff - CW'(1);
                  sum_in    = sum_ff - SUM_W'(top_ff);
                  if (count_ff == CW'(1)) begin
                     // Last word gone: nothing to fetch and nothing to divide.
                     state_in = ST_REPLY;
                  end else begin
                     rd_en    = 1'b1;
                     state_in = ST_LOAD;
                  end
               end
            end
         end
         ST_LOAD: begin
            top_in   = rd_entry.value;
            min_in   = rd_entry.run_min;
            max_in   = rd_entry.run_max;
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               mean_in  = div_quotient;
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            // Statistics of an empty stack all read zero.
            r_popped_in  = popped_ff;
            r_top_in     = empty_now ? '0 : top_ff;
            r_base_in    = empty_now ? '0 : base_ff;
            r_count_in   = count_ff;
            r_sum_in     = empty_now ? '0 : sum_ff;
            r_min_in     = empty_now ? '0 : min_ff;
            r_max_in     = empty_now ? '0 : max_ff;
            r_mean_in    = empty_now ? '0 : mean_ff;
            r_empty_in   = empty_now;
            r_fault_in   = fault_ff;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      top_ff      <= top_in;
      min_ff      <= min_in;
      max_ff      <= max_in;
      base_ff     <= base_in;
      popped_ff   <= popped_in;
      fault_ff    <= fault_in;
      mean_ff     <= mean_in;
      r_popped_ff <= r_popped_in;
      r_top_ff    <= r_top_in;
      r_base_ff   <= r_base_in;
      r_count_ff  <= r_count_in;
      r_sum_ff    <= r_sum_in;
      r_min_ff    <= r_min_in;
      r_max_ff    <= r_max_in;
      r_mean_ff   <= r_mean_in;
      r_empty_ff  <= r_empty_in;
      r_fault_ff  <= r_fault_in;
   end

   // Each memory word holds a value with the running minimum and maximum
   // from the base of the stack up to that value.
   stk_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   stk_div #(
      .CW (CW)
   ) u_mean_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_popped_value   = r_popped_ff;
   assign rsp_top_value      = r_top_ff;
   assign rsp_base_value     = r_base_ff;
   assign rsp_entry_count    = r_count_ff;
   assign rsp_total_sum      = r_sum_ff;
   assign rsp_least_value    = r_min_ff;
   assign rsp_greatest_value = r_max_ff;
   assign rsp_mean_value     = r_mean_ff;
   assign rsp_is_empty       = r_empty_ff;
   assign rsp_fault          = r_fault_ff;

endmodule

@@ rtl/stk_checker.sv @@
module stk_checker #(
   parameter int DEPTH = 256,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic                                 rsp_valid,
   input logic signed [stk_pkg::VALUE_W-1:0]   rsp_top_value,
   input logic [CW-1:0]                        rsp_entry_count,
   input logic signed [stk_pkg::SUM_W-1:0]     rsp_total_sum,
   input logic signed [stk_pkg::VALUE_W-1:0]   rsp_least_value,
   input logic signed [stk_pkg::VALUE_W-1:0]   rsp_greatest_value,
   input logic signed [stk_pkg::VALUE_W-1:0]   rsp_mean_value,
   input logic                                 rsp_is_empty
);

   // A taken request must make the unit go busy.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken without going busy");

   // Results never come back to back: each request yields a single word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two result words in successive cycles");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_entry_count == '0)))
      else $error("empty flag disagrees with count");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_empty) |->
         (rsp_total_sum == '0 && rsp_mean_value == '0 && rsp_least_value == '0))
      else $error("statistics of an empty stack not zero");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_empty) |->
         (rsp_least_value <= rsp_top_value && rsp_top_value <= rsp_greatest_value))
      else $error("top word outside running minimum and maximum");

endmodule

bind stack_with_running_stats_unit stk_checker #(.DEPTH(DEPTH)) u_stk_checker (.*);
